@@ rtl/core/lse_pkg.sv @@
package lse_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int BPP_W     = 4;
    localparam int DIM_W     = 10;
    localparam int CNT_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_BITS = 8;

    // Stream data widths, padded to whole bytes
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
    localparam logic [DIM_W-1:0] WIDTH_RST   = 10'd512;
    localparam logic [DIM_W-1:0] HEIGHT_RST  = 10'd512;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITS_PER_PIXEL = 2'd0,
        CFG_GRID_SPACING   = 2'd1,
        CFG_IMAGE_WIDTH    = 2'd2,
        CFG_IMAGE_HEIGHT   = 2'd3
    } t_cfg_reg;

endpackage

@@ rtl/core/lsb_stego_extractor_core.sv @@
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] original_pixel, tdata[15:8] stego_pixel; tuser image_start
// m_axis    out  tdata[7:0] message_char, tdata[25:8] char_count; tuser char_valid;
//                tlast image_done
// cfg       in   i_cfg_we, i_cfg_addr (register index), i_cfg_data
//
// One pixel pair per cycle: the position/phase counters and the byte
// accumulator update in the cycle of the input beat, and the result lands in
// the output register. Throughput is one beat per cycle as long as the
// output register is drained. The input stalls only while a result sits in
// the output register and the sink holds tready low.
// Synchronous active-low reset clears all counters and loads register defaults.
module lsb_stego_extractor_core #(
    parameter int MAX_DIM = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [lse_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [lse_pkg::DIM_W-1:0]     i_cfg_data,
    // Pixel pair input
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [lse_pkg::S_DATA_W-1:0]  i_s_axis_tdata,  // [7:0] original, [15:8] stego
    input  logic                          i_s_axis_tuser,  // image_start
    // Result output
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lse_pkg::M_DATA_W-1:0]  o_m_axis_tdata,  // [7:0] char, [25:8] count
    output logic                          o_m_axis_tuser,  // char_valid
    output logic                          o_m_axis_tlast   // image_done
);
    import lse_pkg::*;

    localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CMP_W = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
    localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

    // Configuration registers
    logic [BPP_W-1:0] r_bpp;
    logic [DIM_W-1:0] r_spacing;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    // Image state
    logic [POS_W-1:0] r_row, r_col, r_row_ph, r_col_ph;
    logic             r_hdr_skipped;
    logic [PIX_W-1:0] r_acc;
    logic [BPP_W-1:0] r_bits;
    logic             r_stopped;
    logic [CNT_W-1:0] r_count;

    logic [POS_W-1:0] n_row, n_col, n_row_ph, n_col_ph;
    logic             n_hdr_skipped;
    logic [PIX_W-1:0] n_acc;
    logic [BPP_W-1:0] n_bits;
    logic             n_stopped;
    logic [CNT_W-1:0] n_count;

    // Output register
    logic             r_out_valid, r_char_valid, r_done;
    logic [PIX_W-1:0] r_char;
    logic [CNT_W-1:0] r_out_count;
    logic             n_emit, n_done;
    logic [PIX_W-1:0] n_char;

    // Working values
    logic             accept;
    logic [POS_W-1:0] c_row, c_col, c_row_ph, c_col_ph;
    logic             c_hdr, c_stopped;
    logic [PIX_W-1:0] c_acc;
    logic [BPP_W-1:0] c_bits;
    logic [CNT_W-1:0] c_count;
    logic [CMP_W-1:0] w_clamp, h_clamp, d_ext, d_m1;
    logic             hide, last_col, last_row;
    logic [BPP_W:0]   total;
    logic [PIX_W-1:0] diff, mask, chunk, acc_merged;
    logic [CMP_W-1:0] col_inc, row_inc, col_ph_inc, row_ph_inc;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp     <= '0;
            r_spacing <= '0;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_BITS_PER_PIXEL: r_bpp     <= i_cfg_data[BPP_W-1:0];
                CFG_GRID_SPACING:   r_spacing <= i_cfg_data;
                CFG_IMAGE_WIDTH:    r_width   <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1..MAX_DIM
    always_comb begin
        w_clamp = CMP_W'(r_width);
        if (w_clamp == '0)           w_clamp = CMP_W'(1);
        else if (w_clamp > DIM_LIMIT) w_clamp = DIM_LIMIT;
        h_clamp = CMP_W'(r_height);
        if (h_clamp == '0)           h_clamp = CMP_W'(1);
        else if (h_clamp > DIM_LIMIT) h_clamp = DIM_LIMIT;
    end

    assign d_ext = CMP_W'(r_spacing);
    assign d_m1  = d_ext - CMP_W'(1);

    // Image start clears state before the pixel is handled
    always_comb begin
        if (i_s_axis_tuser) begin
            c_row = '0; c_col = '0; c_row_ph = '0; c_col_ph = '0;
            c_hdr = 1'b0; c_stopped = 1'b0; c_acc = '0; c_bits = '0; c_count = '0;
        end else begin
            c_row = r_row; c_col = r_col; c_row_ph = r_row_ph; c_col_ph = r_col_ph;
            c_hdr = r_hdr_skipped; c_stopped = r_stopped; c_acc = r_acc;
            c_bits = r_bits; c_count = r_count;
        end
    end

    // Hiding pixel test and chunk extraction
    assign hide = (r_bpp != '0) && (r_spacing != '0)
               && (CMP_W'(c_row_ph) == d_m1) && (CMP_W'(c_col_ph) == d_m1);
    assign total      = (BPP_W+1)'(c_bits) + (BPP_W+1)'(r_bpp);
    assign diff       = i_s_axis_tdata[S_DATA_W-1:PIX_W] - i_s_axis_tdata[PIX_W-1:0];
    assign mask       = PIX_W'((16'd1 << r_bpp) - 16'd1);
    assign chunk      = diff & mask;
    assign acc_merged = c_acc | PIX_W'(chunk << c_bits);

    // Byte assembly
    always_comb begin
        n_hdr_skipped = c_hdr;
        n_stopped     = c_stopped;
        n_acc         = c_acc;
        n_bits        = c_bits;
        n_count       = c_count;
        n_emit        = 1'b0;
        n_char        = '0;
        if (hide) begin
            if (!c_hdr) begin
                n_hdr_skipped = 1'b1;
            end else if (!c_stopped) begin
                if (total > (BPP_W+1)'(BYTE_BITS)) begin
                    n_stopped = 1'b1;
                end else if (total == (BPP_W+1)'(BYTE_BITS)) begin
                    if (acc_merged != '0) begin
                        n_emit = 1'b1;
                        n_char = acc_merged;
                        if (c_count != COUNT_MAX) n_count = c_count + CNT_W'(1);
                        n_acc  = '0;
                        n_bits = '0;
                    end else begin
                        n_acc     = acc_merged;
                        n_stopped = 1'b1;
                    end
                end else begin
                    n_acc  = acc_merged;
                    n_bits = total[BPP_W-1:0];
                end
            end
        end
    end

    // Raster position advance
    assign col_inc    = CMP_W'(c_col) + CMP_W'(1);
    assign row_inc    = CMP_W'(c_row) + CMP_W'(1);
    assign col_ph_inc = CMP_W'(c_col_ph) + CMP_W'(1);
    assign row_ph_inc = CMP_W'(c_row_ph) + CMP_W'(1);
    assign last_col   = col_inc >= w_clamp;
    assign last_row   = row_inc >= h_clamp;
    assign n_done     = last_col && last_row;

    always_comb begin
        n_row    = c_row;
        n_col    = c_col;
        n_row_ph = c_row_ph;
        n_col_ph = c_col_ph;
        if (n_done) begin
            n_row = '0; n_col = '0; n_row_ph = '0; n_col_ph = '0;
        end else if (last_col) begin
            n_col    = '0;
            n_col_ph = '0;
            n_row    = row_inc[POS_W-1:0];
            n_row_ph = (row_ph_inc >= d_ext) ? '0 : row_ph_inc[POS_W-1:0];
        end else begin
            n_col    = col_inc[POS_W-1:0];
            n_col_ph = (col_ph_inc >= d_ext) ? '0 : col_ph_inc[POS_W-1:0];
        end
    end

    // State update per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0; r_col <= '0; r_row_ph <= '0; r_col_ph <= '0;
            r_hdr_skipped <= 1'b0; r_acc <= '0; r_bits <= '0;
            r_stopped <= 1'b0; r_count <= '0;
        end else if (accept) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_row_ph <= n_row_ph;
            r_col_ph <= n_col_ph;
            if (n_done) begin
                r_hdr_skipped <= 1'b0; r_acc <= '0; r_bits <= '0;
                r_stopped <= 1'b0; r_count <= '0;
            end else begin
                r_hdr_skipped <= n_hdr_skipped;
                r_acc         <= n_acc;
                r_bits        <= n_bits;
                r_stopped     <= n_stopped;
                r_count       <= n_count;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit || n_done;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char_valid <= n_emit;
            r_char       <= n_char;
            r_done       <= n_done;
            r_out_count  <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_DATA_W-CNT_W-PIX_W)'(0), r_out_count, r_char};
    assign o_m_axis_tuser  = r_char_valid;
    assign o_m_axis_tlast  = r_done;

    // A result is either a character or the end-of-image report
    a_result_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_char_valid || r_done))
        else $error("result beat with neither character nor image end");

    // An emitted character is never the terminating zero byte
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_char_valid) |-> (r_char != '0))
        else $error("zero byte emitted as character");

    // Partial byte never holds a full byte
    a_bits_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits < BPP_W'(BYTE_BITS))
        else $error("bit counter reached a full byte");

endmodule
